### rtl/twsw_pkg.sv
`timescale 1ns / 1ps
package twsw_pkg;

    localparam int ADDR_W     = 3;
    localparam int REG_W      = 5;
    localparam int DATA_W     = 16;
    localparam int FRAME_BITS = ADDR_W + 1 + REG_W + DATA_W;

    // Snapshot sequence: one lead-in, two per frame bit, four for the tail.
    localparam int STEPS  = 1 + 2 * FRAME_BITS + 4;
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [STEP_W-1:0] STEP_FIRST_BIT = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST_BIT  = STEP_W'(2 * FRAME_BITS);
    localparam logic [STEP_W-1:0] STEP_SEL_HIGH  = STEP_W'(2 * FRAME_BITS + 2);
    localparam logic [STEP_W-1:0] STEP_TAIL_CLK  = STEP_W'(2 * FRAME_BITS + 3);
    localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(STEPS - 1);

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctl_t;

endpackage

### rtl/three_wire_serial_write_framer_unit.sv
`timescale 1ns / 1ps
// Three-wire serial write framer.
// Input channel (in_valid/in_ready) takes one write request per beat:
// device_address, register_index and write_data. The request is framed as
// address, a zero write bit, register index, data (25 bits, MSB first).
// Output channel (out_valid/out_ready) delivers line snapshots, one per beat:
// select_line, clock_line, data_line, frame_end. Each request yields 55
// snapshots; the last carries frame_end.
// A request beat starts the sequencer at its first step; the first snapshot
// is registered in the output register once the output slot is free.
// Each request occupies the sequencer for all of its snapshots; the step
// counter advances one snapshot per cycle while the receiver does not stall.
// The next request is taken in the same cycle the final snapshot enters the
// output register, so requests run back to back.
// A stalled receiver holds the output register and freezes the sequencer
// and the cell chain; nothing is dropped.
// Reset clears the busy flag, the step counter, the output valid and the
// held data level (the level shown on the first snapshot of a request).
module three_wire_serial_write_framer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [twsw_pkg::ADDR_W-1:0]      device_address,
    input  logic [twsw_pkg::REG_W-1:0]       register_index,
    input  logic [twsw_pkg::DATA_W-1:0]      write_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             select_line,
    output logic                             clock_line,
    output logic                             data_line,
    output logic                             frame_end
);
    import twsw_pkg::*;

    logic              busy_reg,  busy_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              level_reg, level_next;   // data line level, held between requests
    logic              ovalid_reg, ovalid_next;
    logic              sel_reg, clk_reg, end_reg;
    logic              sel_next, clk_next, end_next;

    logic              advance;
    logic              in_beat;
    logic              in_bit_phase;
    logic              head_bit;
    chain_ctl_t        chain_ctl;

    // Produce a snapshot whenever a request is running and the output slot frees up.
    assign advance  = busy_reg && (!ovalid_reg || out_ready);
    // Accept while idle, or while the final snapshot is being produced.
    assign in_ready = !busy_reg || (advance && (step_reg == STEP_LAST));
    assign in_beat  = in_valid && in_ready;

    assign in_bit_phase = (step_reg >= STEP_FIRST_BIT) && (step_reg <= STEP_LAST_BIT);

    // Load the chain on a request beat; shift after each clock-high snapshot.
    assign chain_ctl.load  = in_beat;
    assign chain_ctl.shift = advance && in_bit_phase && !step_reg[0];

    twsw_chain u_chain (
        .clk      (clk),
        .ctl      (chain_ctl),
        .frame_in ({device_address, 1'b0, register_index, write_data}),
        .head_bit (head_bit)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        level_next  = level_reg;
        ovalid_next = ovalid_reg;
        sel_next    = sel_reg;
        clk_next    = clk_reg;
        end_next    = end_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (advance)
        begin
            ovalid_next = 1'b1;
            sel_next    = (step_reg >= STEP_SEL_HIGH);
            end_next    = (step_reg == STEP_LAST);
            // Odd steps in the bit phase drive a new bit with clock low;
            // even ones raise the clock on that bit.
            clk_next    = (in_bit_phase && !step_reg[0]) || (step_reg == STEP_TAIL_CLK);
            if (in_bit_phase && step_reg[0])
            begin
                level_next = head_bit;
            end

            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end

        if (in_beat)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            level_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            level_reg  <= level_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        clk_reg <= clk_next;
        end_reg <= end_next;
    end

    assign out_valid   = ovalid_reg;
    assign select_line = sel_reg;
    assign clock_line  = clk_reg;
    assign data_line   = level_reg;
    assign frame_end   = end_reg;

    // The step counter never runs past the final snapshot.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("step counter out of range");

    // An idle sequencer sits at the first step.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == '0))
        else $error("idle with nonzero step");

    // The marked snapshot always shows select released.
    a_end_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (select_line && !clock_line))
        else $error("frame end without select high");

    // A request beat starts a run at the first step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (busy_reg && (step_reg == '0)))
        else $error("request not started");

endmodule

### rtl/twsw_cell.sv
`timescale 1ns / 1ps
module twsw_cell (
    input  logic                  clk,
    input  twsw_pkg::chain_ctl_t  ctl,
    input  logic                  load_bit,
    input  logic                  prev_bit,
    output logic                  bit_out
);
    import twsw_pkg::*;

    logic bit_reg;
    logic bit_next;

    // Load takes priority; otherwise take the neighbor's bit on a shift.
    always_comb
    begin
        bit_next = bit_reg;
        if (ctl.load)
        begin
            bit_next = load_bit;
        end
        else if (ctl.shift)
        begin
            bit_next = prev_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_out = bit_reg;

endmodule

### rtl/twsw_chain.sv
`timescale 1ns / 1ps
module twsw_chain (
    input  logic                                clk,
    input  twsw_pkg::chain_ctl_t                ctl,
    input  logic [twsw_pkg::FRAME_BITS-1:0]     frame_in,
    output logic                                head_bit
);
    import twsw_pkg::*;

    logic [FRAME_BITS-1:0] cell_bits;

    // Cell FRAME_BITS-1 is the head; bits move one cell toward it per shift.
    for (genvar i = 0; i < FRAME_BITS; i++)
    begin : g_cell
        logic prev;
        if (i == 0)
        begin : g_tail
            assign prev = 1'b0;
        end
        else
        begin : g_mid
            assign prev = cell_bits[i-1];
        end

        twsw_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .load_bit (frame_in[i]),
            .prev_bit (prev),
            .bit_out  (cell_bits[i])
        );
    end

    assign head_bit = cell_bits[FRAME_BITS-1];

endmodule

### tb/serial_frame_checker.sv
`timescale 1ns / 1ps
module serial_frame_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [twsw_pkg::ADDR_W-1:0] device_address,
    input  logic [twsw_pkg::REG_W-1:0]  register_index,
    input  logic [twsw_pkg::DATA_W-1:0] write_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        select_line,
    input  logic                        clock_line,
    input  logic                        data_line,
    input  logic                        frame_end,
    output int                          mismatch_count,
    output int                          pending_snapshots,
    output int                          snapshots_checked
);
    import twsw_pkg::*;

    typedef struct packed {
        logic select_lvl;
        logic clock_lvl;
        logic data_lvl;
        logic frame_last;
    } line_snapshot_t;

    line_snapshot_t expected_snapshots[$];
    logic           held_data_level;

    function automatic line_snapshot_t lines(input logic sel, input logic sclk,
                                             input logic dat, input logic last);
        line_snapshot_t s;
        s.select_lvl = sel;
        s.clock_lvl  = sclk;
        s.data_lvl   = dat;
        s.frame_last = last;
        return s;
    endfunction

    // Queue the 55 line levels one write request produces.
    function automatic void queue_frame_snapshots(input logic [ADDR_W-1:0] dev_addr,
                                                  input logic [REG_W-1:0]  reg_idx,
                                                  input logic [DATA_W-1:0] wdata);
        logic [FRAME_BITS-1:0] frame;
        logic                  dat;
        frame = {dev_addr, 1'b0, reg_idx, wdata};
        dat   = held_data_level;
        expected_snapshots.push_back(lines(1'b0, 1'b0, dat, 1'b0));
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            dat = frame[i];
            expected_snapshots.push_back(lines(1'b0, 1'b0, dat, 1'b0));
            expected_snapshots.push_back(lines(1'b0, 1'b1, dat, 1'b0));
        end
        expected_snapshots.push_back(lines(1'b0, 1'b0, dat, 1'b0));
        expected_snapshots.push_back(lines(1'b1, 1'b0, dat, 1'b0));
        expected_snapshots.push_back(lines(1'b1, 1'b1, dat, 1'b0));
        expected_snapshots.push_back(lines(1'b1, 1'b0, dat, 1'b1));
        held_data_level = dat;
    endfunction

    function automatic void check_level(input string field_name, input logic want,
                                        input logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0b, got %0b", field_name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        line_snapshot_t want;
        if (!rst_n)
        begin
            expected_snapshots.delete();
            held_data_level = 1'b0;
        end
        else
        begin
            // Check the output beat first so a snapshot can never match a
            // request accepted on the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_snapshots.size() == 0)
                begin
                    $error("unexpected snapshot: select %0b clock %0b data %0b end %0b",
                           select_line, clock_line, data_line, frame_end);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_snapshots.pop_front();
                    check_level("select_line", want.select_lvl, select_line);
                    check_level("clock_line", want.clock_lvl, clock_line);
                    check_level("data_line", want.data_lvl, data_line);
                    check_level("frame_end", want.frame_last, frame_end);
                    snapshots_checked++;
                end
            end
            if (in_valid && in_ready)
                queue_frame_snapshots(device_address, register_index, write_data);
        end
        pending_snapshots = expected_snapshots.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import twsw_pkg::*;

    // Pacing of one side of the block: random idle cycles, or none at all.
    typedef enum logic {
        PACE_RANDOM,
        PACE_FREE
    } pace_t;

    localparam int IDLE_PERCENT = 35;
    localparam int HOLD_CYCLES  = 400;
    // A full frame is 55 snapshots; wait out a drain period so any stray beat can show.
    localparam int DRAIN_CYCLES = 60;

    logic              clk;
    logic              rst_n;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ADDR_W-1:0] device_address = '0;
    logic [REG_W-1:0]  register_index = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              select_line;
    logic              clock_line;
    logic              data_line;
    logic              frame_end;

    int    mismatch_count;
    int    pending_snapshots;
    int    snapshots_checked;
    int    requests_sent = 0;
    pace_t tx_pace = PACE_RANDOM;
    pace_t rx_pace = PACE_RANDOM;
    // Nonzero asks the receiver process to hold off ready, for the length it gives.
    int    rx_hold_cycles = 0;

    three_wire_serial_write_framer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .device_address (device_address),
        .register_index (register_index),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .select_line    (select_line),
        .clock_line     (clock_line),
        .data_line      (data_line),
        .frame_end      (frame_end)
    );

    serial_frame_checker frame_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .device_address    (device_address),
        .register_index    (register_index),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .select_line       (select_line),
        .clock_line        (clock_line),
        .data_line         (data_line),
        .frame_end         (frame_end),
        .mismatch_count    (mismatch_count),
        .pending_snapshots (pending_snapshots),
        .snapshots_checked (snapshots_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hold reset, then release it once, away from the edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Give up if the run hangs; even a fully stalled correct run ends far sooner.
    initial
    begin
        #10_000_000;
        $display("three_wire_serial_write_framer_unit verification failed");
        $finish;
    end

    // Receiver: drive out_ready once per edge outside a hold-off, which drops
    // ready for a counted stretch; otherwise stall at random or accept every beat.
    initial
    begin
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                for (held = 1; held < rx_hold_cycles; held++)
                    @(posedge clk);
                rx_hold_cycles = 0;
            end
            else if (rx_pace == PACE_FREE)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Present one request and hold it until the beat goes through. Called on
    // a clock edge; returns on the edge of the beat with valid still high.
    task automatic offer_request(input logic [ADDR_W-1:0] dev_addr,
                                 input logic [REG_W-1:0]  reg_idx,
                                 input logic [DATA_W-1:0] wdata);
        in_valid       <= 1'b1;
        device_address <= dev_addr;
        register_index <= reg_idx;
        write_data     <= wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // In random pacing, drop valid for a random run of idle cycles before the next request.
    task automatic sender_gap();
        if (tx_pace == PACE_RANDOM)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic offer_random_request();
        sender_gap();
        offer_request(ADDR_W'($urandom_range(7)), REG_W'($urandom_range(31)),
                      DATA_W'($urandom_range(65535)));
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);

        // Directed: first frame after reset starts from a low data line, then
        // all ones, then back to zeros so the lead-in shows a held high level.
        // Walk single bits and alternating patterns through every field.
        offer_request(3'd0, 5'd0,  16'h0000);
        sender_gap();
        offer_request(3'd7, 5'd31, 16'hFFFF);
        sender_gap();
        offer_request(3'd0, 5'd0,  16'h0000);
        sender_gap();
        offer_request(3'd1, 5'd0,  16'h0001);
        sender_gap();
        offer_request(3'd2, 5'd1,  16'h8000);
        sender_gap();
        offer_request(3'd4, 5'd16, 16'h0000);
        sender_gap();
        offer_request(3'd5, 5'd10, 16'hAAAA);
        sender_gap();
        offer_request(3'd2, 5'd21, 16'h5555);
        sender_gap();
        offer_request(3'd3, 5'd31, 16'h00FF);
        sender_gap();
        offer_request(3'd6, 5'd0,  16'hFF00);
        sender_gap();
        offer_request(3'd7, 5'd0,  16'h0001);
        sender_gap();
        offer_request(3'd0, 5'd31, 16'h8000);

        // Random traffic with idle cycles on both sides.
        repeat (80) offer_random_request();

        // Long stretch with no idling on either side: back-to-back frames.
        tx_pace = PACE_FREE;
        rx_pace = PACE_FREE;
        repeat (40) offer_random_request();

        // Stall the receiver for a long stretch while requests keep coming,
        // so the output register and the input side both back up.
        rx_hold_cycles = HOLD_CYCLES;
        repeat (4) offer_random_request();

        // Pause the sender until every snapshot in flight has been delivered;
        // step past the beat edge so the last request is already queued.
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_snapshots == 0);
        @(posedge clk);

        tx_pace = PACE_RANDOM;
        rx_pace = PACE_RANDOM;
        repeat (80) offer_random_request();
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then allow time for any stray beat to show up.
        wait (pending_snapshots == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d write requests and %0d line snapshots: directed bit patterns,",
                 requests_sent, snapshots_checked);
        $display("random idling, back-to-back frames, a long output stall and a full drain.");
        if (mismatch_count == 0)
            $display("three_wire_serial_write_framer_unit verification clean");
        else
            $display("three_wire_serial_write_framer_unit verification failed");
        $finish;
    end

endmodule
